// ===== rtl/sha1s_pkg.sv =====
package sha1s_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 61;
   localparam int LEN_W   = 64;

   localparam logic [WORD_W-1:0] H_INIT [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [WORD_W-1:0] K_ROUND [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

   // Control from the sequencer to the message schedule.
   typedef struct packed {
      logic       load;      // take one message or pad byte
      logic       word_end;  // byte completes a 32-bit word
      logic       step;      // advance one compression round
      logic [7:0] data;
   } sched_ctl_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

   // Round function; grp selects the 20-round group.
   function automatic logic [WORD_W-1:0] round_f(input logic [1:0] grp,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      unique case (grp)
         2'd0:    round_f = (b & c) | (~b & d);
         2'd2:    round_f = (b & c) | (b & d) | (c & d);
         default: round_f = b ^ c ^ d;
      endcase
   endfunction

endpackage

// ===== rtl/sha1s_sched.sv =====
module sha1s_sched import sha1s_pkg::*; (
   input  logic                clock,
   input  sched_ctl_type       ctl,
   output logic [WORD_W-1:0]   w_cur
);

   logic [23:0]       acc_ff, acc_in;
   logic [WORD_W-1:0] w_ff [16];
   logic [WORD_W-1:0] w_in;
   logic              shift_en;

   always_comb begin
      acc_in   = acc_ff;
      w_in     = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
      shift_en = 1'b0;
      if (ctl.load) begin
         acc_in = {acc_ff[15:0], ctl.data};
         if (ctl.word_end) begin
            w_in     = {acc_ff, ctl.data};
            shift_en = 1'b1;
         end
      end else if (ctl.step) begin
         shift_en = 1'b1;
      end
   end

   // Oldest word sits at index 0; new words enter at index 15.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_in;
      end
   end

   assign w_cur = w_ff[0];

endmodule

// ===== rtl/sha1_stream_hasher.sv =====
// SHA-1 over a byte stream. Each req transfer carries an optional byte (tuser high) and
// an end-of-message mark (tlast). The byte that fills a 64-byte block holds req_tready
// low for the 80 rounds of the single shared round unit and the chaining add. A last
// transfer then pads one byte per cycle to the end of the block and compresses it; when
// the length no longer fits, up to 8 pad bytes and one compression come first. The digest
// then leaves as five rsp transfers, h0 first, word index in tuser and tlast on the fifth.
// The hasher then returns to its initial chaining values for the next message.
module sha1_stream_hasher import sha1s_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_ADD, S_EMIT} state_type;
   typedef enum logic [2:0] {PAD_NONE, PAD_ONE, PAD_ZERO, PAD_LEN, PAD_DONE} pad_type;

   state_type         state_ff, state_in;
   pad_type           pad_ff, pad_in;
   logic [5:0]        fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [6:0]        round_ff, round_in;
   logic [2:0]        idx_ff, idx_in;
   logic [WORD_W-1:0] chain_ff [5];
   logic [WORD_W-1:0] chain_in [5];
   logic [WORD_W-1:0] work_ff [5];
   logic [WORD_W-1:0] work_in [5];
   logic [LEN_W-1:0]  len_ff, len_in;

   sched_ctl_type     ctl;
   logic [WORD_W-1:0] w_cur;
   logic [WORD_W-1:0] t_sum;
   logic [1:0]        grp;
   logic              req_xfer, rsp_xfer, block_full;

   sha1s_sched u_sched (
      .clock (clock),
      .ctl   (ctl),
      .w_cur (w_cur)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = chain_ff[0];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 3'd4);

   always_comb begin
      if (round_ff < 7'd20)      grp = 2'd0;
      else if (round_ff < 7'd40) grp = 2'd1;
      else if (round_ff < 7'd60) grp = 2'd2;
      else                       grp = 2'd3;
      t_sum = rotl(work_ff[0], 5) + round_f(grp, work_ff[1], work_ff[2], work_ff[3])
            + work_ff[4] + K_ROUND[grp] + w_cur;
   end

   always_comb begin
      state_in = state_ff;
      pad_in   = pad_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      len_in   = len_ff;
      ctl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               ctl.load = req_tuser;
               ctl.data = req_tdata;
               if (req_tuser) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               len_in = {count_in, 3'b000};
               pad_in = req_tlast ? PAD_ONE : PAD_NONE;
               if (req_tlast) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            ctl.load = 1'b1;
            unique case (pad_ff)
               PAD_ONE: begin
                  ctl.data = PAD_MARK;
                  pad_in   = (fill_ff == 6'd55) ? PAD_LEN : PAD_ZERO;
               end
               PAD_LEN: begin
                  ctl.data = len_ff[LEN_W-1 -: 8];
                  len_in   = {len_ff[LEN_W-9:0], 8'h00};
                  pad_in   = (fill_ff == 6'd63) ? PAD_DONE : PAD_LEN;
               end
               default: begin
                  ctl.data = 8'h00;
                  pad_in   = (fill_ff == 6'd55) ? PAD_LEN : PAD_ZERO;
               end
            endcase
         end
         S_ROUND: begin
            ctl.step   = 1'b1;
            work_in[0] = t_sum;
            work_in[1] = work_ff[0];
            work_in[2] = rotl(work_ff[1], 30);
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            round_in   = round_ff + 7'd1;
            if (round_ff == 7'd79) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            priority case (pad_ff)
               PAD_DONE: state_in = S_EMIT;
               PAD_NONE: state_in = S_IDLE;
               default:  state_in = S_PAD;
            endcase
            idx_in = 3'd0;
         end
         S_EMIT: begin
            if (rsp_xfer) begin
               // rotate so the next word is presented from chain_ff[0]
               for (int i = 0; i < 4; i++) begin
                  chain_in[i] = chain_ff[i+1];
               end
               chain_in[4] = chain_ff[0];
               idx_in      = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  chain_in = H_INIT;
                  count_in = '0;
                  pad_in   = PAD_NONE;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      ctl.word_end = (fill_ff[1:0] == 2'b11);
      block_full   = ctl.load && (fill_ff == 6'd63);
      if (ctl.load) begin
         fill_in = fill_ff + 6'd1;
      end
      if (block_full) begin
         work_in  = chain_ff;
         round_in = '0;
         state_in = S_ROUND;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      len_ff  <= len_in;
      if (reset) begin
         state_ff <= S_IDLE;
         pad_ff   <= PAD_NONE;
         fill_ff  <= '0;
         count_ff <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         chain_ff <= H_INIT;
      end else begin
         state_ff <= state_in;
         pad_ff   <= pad_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result sides open together");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (round_ff < 7'd80))
      else $error("round counter out of range");

   a_emit_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fill_ff == 6'd0 && idx_ff <= 3'd4))
      else $error("digest shown with partial block");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast) |=> (req_tready && count_ff == '0))
      else $error("hasher not restarted after digest");

   a_pad_starts: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast && !(req_tuser && fill_ff == 6'd63)) |=> (state_ff == S_PAD))
      else $error("padding did not start after last transfer");

endmodule
